FILE: rtl/es2cal_pkg.sv
package es2cal_pkg;

    // Field widths
    localparam int TS_W    = 32;
    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int WDAY_W  = 3;
    localparam int YEAR_W  = 12;
    localparam int YDAY_W  = 9;
    localparam int MON_W   = 4;
    localparam int MDAY_W  = 5;

    // Internal widths: whole days since the epoch fit 16 bits (max 49710),
    // whole hours 21 bits, whole minutes 27 bits.
    localparam int DAYS_W  = 16;
    localparam int HOURS_W = 21;
    localparam int Q60_W   = 27;

    localparam int SECS_PER_MIN  = 60;
    localparam int MINS_PER_HOUR = 60;
    localparam int HOURS_PER_DAY = 24;
    localparam int DAYS_PER_WEEK = 7;
    localparam int MONTHS        = 12;

    // Reciprocal multipliers, exact for every 32-bit dividend
    localparam logic [31:0] RECIP_60       = 32'h8888_8889;
    localparam int          RECIP_60_SHIFT = 37;
    localparam logic [31:0] RECIP_24       = 32'hAAAA_AAAB;
    localparam int          RECIP_24_SHIFT = 36;
    // Slightly above 1/7, exact for 16-bit dividends
    localparam logic [16:0] RECIP_7        = 17'd74899;
    localparam int          RECIP_7_SHIFT  = 19;
    // Slightly above 1/365.25: estimate lands on the true year or one below
    localparam logic [15:0] RECIP_YEAR     = 16'd45934;
    localparam int          YEAR_SHIFT     = 24;

    localparam int          EPOCH_YEAR = 1970;
    localparam logic [WDAY_W-1:0] EPOCH_WDAY = 3'd4;    // Thursday

    // Year starts 1970 through 2107 (one past the last reachable year)
    localparam int YEAR_SLOTS = 138;
    localparam int YIDX_W     = $clog2(YEAR_SLOTS);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [YEAR_SLOTS-1:0][DAYS_W-1:0] year_tab_t;
    typedef logic [YEAR_SLOTS-1:0]             leap_tab_t;

    // Time of day plus whole days, passed from the front to the back end
    typedef struct packed {
        logic [SEC_W-1:0]  sec;
        logic [MIN_W-1:0]  min;
        logic [HOUR_W-1:0] hour;
        logic [DAYS_W-1:0] days;
    } es2cal_tod_t;

    // Within 1970..2107 the only century year that is not leap is 2100
    function automatic logic year_is_leap(logic [31:0] yr);
        return (yr[1:0] == 2'b00) && (yr != 32'd2100);
    endfunction

    function automatic year_tab_t build_year_start();
        year_tab_t   tab;
        int unsigned acc;
        acc = 0;
        for (int i = 0; i < YEAR_SLOTS; i++) begin
            tab[i] = DAYS_W'(acc);
            acc += year_is_leap(32'(EPOCH_YEAR + i)) ? 366 : 365;
        end
        return tab;
    endfunction

    function automatic leap_tab_t build_leap_tab();
        leap_tab_t tab;
        for (int i = 0; i < YEAR_SLOTS; i++) begin
            tab[i] = year_is_leap(32'(EPOCH_YEAR + i));
        end
        return tab;
    endfunction

    localparam year_tab_t YEAR_START = build_year_start();
    localparam leap_tab_t LEAP_TAB   = build_leap_tab();

    // Day of year on which month index mon (0 is January) begins
    function automatic logic [YDAY_W-1:0] month_start(logic [MON_W-1:0] mon, logic leap);
        logic [YDAY_W-1:0] base;
        case (mon)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (mon >= 4'd2)) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

FILE: rtl/es2cal_front.sv
module es2cal_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [es2cal_pkg::TS_W-1:0]    s_timestamp,
    output logic                           item_valid,
    input  logic                           item_ready,
    output es2cal_pkg::es2cal_tod_t        item
);
    import es2cal_pkg::*;

    // Stages: A holds the timestamp, B whole minutes, C whole hours, D whole days
    logic [3:0]              vld_reg;
    logic [3:0]              adv;

    logic [TS_W-1:0]         a_ts_reg;
    logic [Q60_W-1:0]        b_q60_reg;
    logic [SEC_W-1:0]        b_tlo_reg;
    logic [SEC_W-1:0]        c_sec_reg;
    logic [MIN_W-1:0]        c_q60lo_reg;
    logic [HOURS_W-1:0]      c_hours_reg;
    logic [SEC_W-1:0]        d_sec_reg;
    logic [MIN_W-1:0]        d_min_reg;
    logic [HOUR_W-1:0]       d_hlo_reg;
    logic [DAYS_W-1:0]       d_days_reg;

    logic [63:0]             min_prod;
    logic [63:0]             hours_prod;
    logic [63:0]             days_prod;
    logic [Q60_W-1:0]        q60_next;
    logic [SEC_W-1:0]        sec_next;
    logic [HOURS_W-1:0]      hours_next;
    logic [MIN_W-1:0]        min_next;
    logic [DAYS_W-1:0]       days_next;

    // A stage may load when it is empty or its content moves on
    always_comb begin
        adv[3] = !vld_reg[3] || item_ready;
        for (int i = 2; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign s_ready    = adv[0];
    assign item_valid = vld_reg[3];

    always_comb begin
        min_prod   = 64'(a_ts_reg) * 64'(RECIP_60);
        q60_next   = Q60_W'(min_prod >> RECIP_60_SHIFT);

        // remainders need only the low bits of each operand
        sec_next   = b_tlo_reg - SEC_W'(b_q60_reg[SEC_W-1:0] * SEC_W'(SECS_PER_MIN));
        hours_prod = 64'(b_q60_reg) * 64'(RECIP_60);
        hours_next = HOURS_W'(hours_prod >> RECIP_60_SHIFT);

        min_next   = c_q60lo_reg - MIN_W'(c_hours_reg[MIN_W-1:0] * MIN_W'(MINS_PER_HOUR));
        days_prod  = 64'(c_hours_reg) * 64'(RECIP_24);
        days_next  = DAYS_W'(days_prod >> RECIP_24_SHIFT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int i = 1; i < 4; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0] && s_valid) begin
            a_ts_reg <= s_timestamp;
        end
        if (adv[1] && vld_reg[0]) begin
            b_q60_reg <= q60_next;
            b_tlo_reg <= a_ts_reg[SEC_W-1:0];
        end
        if (adv[2] && vld_reg[1]) begin
            c_sec_reg   <= sec_next;
            c_q60lo_reg <= b_q60_reg[MIN_W-1:0];
            c_hours_reg <= hours_next;
        end
        if (adv[3] && vld_reg[2]) begin
            d_sec_reg  <= c_sec_reg;
            d_min_reg  <= min_next;
            d_hlo_reg  <= c_hours_reg[HOUR_W-1:0];
            d_days_reg <= days_next;
        end
    end

    always_comb begin
        item.sec  = d_sec_reg;
        item.min  = d_min_reg;
        item.hour = d_hlo_reg - HOUR_W'(d_days_reg[HOUR_W-1:0] * HOUR_W'(HOURS_PER_DAY));
        item.days = d_days_reg;
    end

endmodule

FILE: rtl/es2cal_queue.sv
module es2cal_queue (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push_valid,
    output logic                      push_ready,
    input  es2cal_pkg::es2cal_tod_t   push_item,
    output logic                      pop_valid,
    input  logic                      pop_ready,
    output es2cal_pkg::es2cal_tod_t   pop_item
);
    import es2cal_pkg::*;

    es2cal_tod_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                push_fire;
    logic                pop_fire;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb begin
        case ({push_fire, pop_fire})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push_fire) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop_fire) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_fire) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_count_push: assert property (@(posedge aclk) disable iff (!aresetn)
        push_fire && !pop_fire |=> count_reg == $past(count_reg) + QCNT_W'(1))
        else $error("queue count missed a push");

endmodule

FILE: rtl/es2cal_back.sv
module es2cal_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  es2cal_pkg::es2cal_tod_t         item,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [es2cal_pkg::SEC_W-1:0]    m_sec_of_minute,
    output logic [es2cal_pkg::MIN_W-1:0]    m_min_of_hour,
    output logic [es2cal_pkg::HOUR_W-1:0]   m_hour_of_day,
    output logic [es2cal_pkg::WDAY_W-1:0]   m_weekday,
    output logic [es2cal_pkg::YEAR_W-1:0]   m_calendar_year,
    output logic [es2cal_pkg::YDAY_W-1:0]   m_day_of_year,
    output logic [es2cal_pkg::MON_W-1:0]    m_month_number,
    output logic [es2cal_pkg::MDAY_W-1:0]   m_day_of_month
);
    import es2cal_pkg::*;

    // E1 takes the queue head, E2 estimates year and week quotient,
    // E3 settles year, day of year and weekday, E4 picks the month, E5 is the output
    localparam int STAGES = 5;

    logic [STAGES-1:0]   vld_reg;
    logic [STAGES-1:0]   adv;

    es2cal_tod_t         e1_reg;
    es2cal_tod_t         e2_reg;
    logic [YIDX_W-1:0]   e2_est_reg;
    logic [WDAY_W-1:0]   e2_xlo_reg;
    logic [WDAY_W-1:0]   e2_wq_reg;

    logic [SEC_W-1:0]    e3_sec_reg;
    logic [MIN_W-1:0]    e3_min_reg;
    logic [HOUR_W-1:0]   e3_hour_reg;
    logic [WDAY_W-1:0]   e3_wday_reg;
    logic [YIDX_W-1:0]   e3_yidx_reg;
    logic [YDAY_W-1:0]   e3_yday_reg;
    logic                e3_leap_reg;

    logic [SEC_W-1:0]    e4_sec_reg;
    logic [MIN_W-1:0]    e4_min_reg;
    logic [HOUR_W-1:0]   e4_hour_reg;
    logic [WDAY_W-1:0]   e4_wday_reg;
    logic [YIDX_W-1:0]   e4_yidx_reg;
    logic [YDAY_W-1:0]   e4_yday_reg;
    logic                e4_leap_reg;
    logic [MON_W-1:0]    e4_mon_reg;

    logic [31:0]         year_prod;
    logic [DAYS_W-1:0]   wk_x;
    logic [39:0]         wk_prod;
    logic [YIDX_W-1:0]   est_next;
    logic [WDAY_W-1:0]   wq_next;

    logic [DAYS_W-1:0]   start_lo;
    logic [DAYS_W-1:0]   start_hi;
    logic                bump;
    logic [YIDX_W-1:0]   yidx_next;
    logic [YDAY_W-1:0]   yday_next;
    logic                leap_next;
    logic [WDAY_W-1:0]   wday_next;

    logic [MON_W-1:0]    mon_next;
    logic [MDAY_W-1:0]   mday_next;
    logic [YEAR_W-1:0]   year_next;

    always_comb begin
        adv[STAGES-1] = !vld_reg[STAGES-1] || m_ready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign item_ready = adv[0];
    assign m_valid    = vld_reg[STAGES-1];

    // E2: year estimate and (days + 4) / 7 by reciprocal
    always_comb begin
        year_prod = 32'(e1_reg.days) * 32'(RECIP_YEAR);
        est_next  = YIDX_W'(year_prod >> YEAR_SHIFT);
        wk_x      = e1_reg.days + DAYS_W'(EPOCH_WDAY);
        wk_prod   = 40'(wk_x) * 40'(RECIP_7);
        wq_next   = WDAY_W'(wk_prod >> RECIP_7_SHIFT);
    end

    // E3: the estimate is the true year or one below; step up if past next start
    always_comb begin
        start_lo  = YEAR_START[e2_est_reg];
        start_hi  = YEAR_START[e2_est_reg + YIDX_W'(1)];
        bump      = (e2_reg.days >= start_hi);
        yidx_next = bump ? e2_est_reg + YIDX_W'(1) : e2_est_reg;
        yday_next = YDAY_W'(e2_reg.days - (bump ? start_hi : start_lo));
        leap_next = LEAP_TAB[yidx_next];
        wday_next = e2_xlo_reg - WDAY_W'(e2_wq_reg * WDAY_W'(DAYS_PER_WEEK));
    end

    // E4: last month whose first day is not after the day of year
    always_comb begin
        mon_next = '0;
        for (int m = 1; m < MONTHS; m++) begin
            if (e3_yday_reg >= month_start(MON_W'(m), e3_leap_reg)) begin
                mon_next = MON_W'(m);
            end
        end
    end

    always_comb begin
        mday_next = MDAY_W'(e4_yday_reg - month_start(e4_mon_reg, e4_leap_reg)) + MDAY_W'(1);
        year_next = YEAR_W'(EPOCH_YEAR) + YEAR_W'(e4_yidx_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= item_valid;
            end
            for (int i = 1; i < STAGES; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0] && item_valid) begin
            e1_reg <= item;
        end
        if (adv[1] && vld_reg[0]) begin
            e2_reg     <= e1_reg;
            e2_est_reg <= est_next;
            e2_xlo_reg <= wk_x[WDAY_W-1:0];
            e2_wq_reg  <= wq_next;
        end
        if (adv[2] && vld_reg[1]) begin
            e3_sec_reg  <= e2_reg.sec;
            e3_min_reg  <= e2_reg.min;
            e3_hour_reg <= e2_reg.hour;
            e3_wday_reg <= wday_next;
            e3_yidx_reg <= yidx_next;
            e3_yday_reg <= yday_next;
            e3_leap_reg <= leap_next;
        end
        if (adv[3] && vld_reg[2]) begin
            e4_sec_reg  <= e3_sec_reg;
            e4_min_reg  <= e3_min_reg;
            e4_hour_reg <= e3_hour_reg;
            e4_wday_reg <= e3_wday_reg;
            e4_yidx_reg <= e3_yidx_reg;
            e4_yday_reg <= e3_yday_reg;
            e4_leap_reg <= e3_leap_reg;
            e4_mon_reg  <= mon_next;
        end
        if (adv[4] && vld_reg[3]) begin
            m_sec_of_minute <= e4_sec_reg;
            m_min_of_hour   <= e4_min_reg;
            m_hour_of_day   <= e4_hour_reg;
            m_weekday       <= e4_wday_reg;
            m_calendar_year <= year_next;
            m_day_of_year   <= e4_yday_reg;
            m_month_number  <= e4_mon_reg + MON_W'(1);
            m_day_of_month  <= mday_next;
        end
    end

    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_month_number >= MON_W'(1)) && (m_month_number <= MON_W'(MONTHS)))
        else $error("month out of range");

    a_day_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_day_of_month != '0) && (m_weekday < WDAY_W'(DAYS_PER_WEEK)))
        else $error("day of month or weekday out of range");

endmodule

FILE: rtl/epoch_seconds_to_calendar_unit.sv
// Channel  Direction  Handshake          Payload
// s_       in         s_valid/s_ready    s_timestamp (32b, seconds since 1970-01-01 UTC)
// m_       out        m_valid/m_ready    sec, min, hour, weekday, year, day of year,
//                                        month, day of month
//
// One transaction per cycle sustained while m_ready stays high; each timestamp
// passes through four front stages for the divides by 60, 60 and 24, one queue
// slot, and five back stages ending in the output register.
// Reset clears the stage valid bits, the queue pointers and the queue count only.
// While m_ready is low the back stages fill, then the 4-entry queue, then the
// front stages; s_ready drops only once all of them hold transactions.
module epoch_seconds_to_calendar_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [es2cal_pkg::TS_W-1:0]     s_timestamp,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [es2cal_pkg::SEC_W-1:0]    m_sec_of_minute,
    output logic [es2cal_pkg::MIN_W-1:0]    m_min_of_hour,
    output logic [es2cal_pkg::HOUR_W-1:0]   m_hour_of_day,
    output logic [es2cal_pkg::WDAY_W-1:0]   m_weekday,
    output logic [es2cal_pkg::YEAR_W-1:0]   m_calendar_year,
    output logic [es2cal_pkg::YDAY_W-1:0]   m_day_of_year,
    output logic [es2cal_pkg::MON_W-1:0]    m_month_number,
    output logic [es2cal_pkg::MDAY_W-1:0]   m_day_of_month
);
    import es2cal_pkg::*;

    logic          fq_valid;
    logic          fq_ready;
    es2cal_tod_t   fq_item;
    logic          qb_valid;
    logic          qb_ready;
    es2cal_tod_t   qb_item;

    es2cal_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_timestamp (s_timestamp),
        .item_valid  (fq_valid),
        .item_ready  (fq_ready),
        .item        (fq_item)
    );

    es2cal_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    es2cal_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .item_valid      (qb_valid),
        .item_ready      (qb_ready),
        .item            (qb_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sec_of_minute (m_sec_of_minute),
        .m_min_of_hour   (m_min_of_hour),
        .m_hour_of_day   (m_hour_of_day),
        .m_weekday       (m_weekday),
        .m_calendar_year (m_calendar_year),
        .m_day_of_year   (m_day_of_year),
        .m_month_number  (m_month_number),
        .m_day_of_month  (m_day_of_month)
    );

endmodule
